// ===== hdl/knnhpr_pkg.sv =====
// Shared types and constants for the histogram nearest-neighbor position unit.
// No dependencies; every other file in hdl uses this package.
`timescale 1ns / 1ps

package knnhpr_pkg;

  // Sizing
  localparam int NUM_REFS     = 256;
  localparam int BINS         = 32;
  localparam int K            = 3;

  localparam int REF_W        = $clog2(NUM_REFS);
  localparam int BIN_W        = $clog2(BINS);
  localparam int ADDR_W       = REF_W + BIN_W;
  localparam int VAL_W        = 16;
  localparam int POS_W        = 16;
  localparam int SQ_W         = 2 * VAL_W;
  localparam int DIST_W       = 38;
  localparam int MEAN_D_W     = 37;
  localparam int SUM_D_W      = DIST_W + 2;
  localparam int SUM_P_W      = POS_W + 2;
  localparam int K_IDX_W      = (K > 1) ? $clog2(K) : 1;
  localparam int REM_W        = $clog2(K + 1);

  // Divide by K one byte per step; the quotient byte comes from a reciprocal multiply
  localparam int DIGIT_W      = 8;
  localparam int DIV_STEPS    = SUM_D_W / DIGIT_W;
  localparam int RECIP_SH     = 11;
  localparam int RECIP_K      = (2**RECIP_SH + K - 1) / K;
  localparam int PROD_W       = REM_W + DIGIT_W + RECIP_SH;

  localparam int DRAIN_CYCLES = 5;
  localparam int STEP_W       = $clog2(DIV_STEPS + 1);

  // Input commands
  typedef enum logic [1:0] {
    CMD_REF_BIN   = 2'd0,
    CMD_REF_POS   = 2'd1,
    CMD_QUERY_BIN = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]              command;
    logic [7:0]              entry;
    logic [4:0]              bin;
    logic [VAL_W-1:0]        bin_value;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] mean_x;
    logic signed [POS_W-1:0] mean_y;
    logic [MEAN_D_W-1:0]     mean_distance;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic               clear_best;
    logic               scan_valid;
    logic [REF_W-1:0]   scan_ref;
    logic [BIN_W-1:0]   scan_bin;
    logic               scan_first;
    logic               scan_last;
    logic               fetch_valid;
    logic [K_IDX_W-1:0] fetch_k;
    logic               div_load;
    logic               div_step;
    logic               out_load;
  } dp_cmd_t;

endpackage

// ===== hdl/knn_histogram_position_regression_unit.sv =====
// Top level of the histogram nearest-neighbor position regression unit.
// Depends on knnhpr_pkg and knnhpr_top_unit (controller and datapath).
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_item   (command, entry, bin, value, x, y, last)
//   out      output     out_valid/out_stall out_item  (mean_x, mean_y, mean_distance)
//
// Loads and non-final query bins are taken whenever the unit is idle.
// A final query bin runs the search: a scan of every reference bin through one
// squarer, a drain of the pipeline, a fetch of the K positions, the divide by K
// a byte per step and a load of the result; the result beat is offered then, or
// later while an older result is stalled. Reset is synchronous; no clearing pass
// is needed. in_stall is high for the whole search; the result waits in the
// output register while out_stall is high.
`timescale 1ns / 1ps

module knn_histogram_position_regression_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  knnhpr_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output knnhpr_pkg::out_item_t out_item
);

  knnhpr_top_unit u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/knnhpr_ctrl.sv =====
// Sequencer for the nearest-neighbor search: scan, drain, fetch, divide, deliver.
// Depends on knnhpr_pkg.
`timescale 1ns / 1ps

module knnhpr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  knnhpr_pkg::in_item_t in_item,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output knnhpr_pkg::dp_cmd_t  cmd
);
  import knnhpr_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [REF_W-1:0]   ref_cnt;
  logic [BIN_W-1:0]   bin_cnt;
  logic [STEP_W-1:0]  step;
  logic               start;
  logic               scan_end;
  logic               out_free;

  assign start    = in_fire && (in_item.command == CMD_QUERY_BIN) && in_item.last;
  assign scan_end = (ref_cnt == REF_W'(NUM_REFS - 1)) && (bin_cnt == BIN_W'(BINS - 1));
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN:  if (scan_end) state_next = ST_DRAIN;
      ST_DRAIN: if (step == STEP_W'(DRAIN_CYCLES - 1)) state_next = ST_FETCH;
      ST_FETCH: if (step == STEP_W'(K)) state_next = ST_DIV;
      ST_DIV:   if (step == STEP_W'(DIV_STEPS)) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd             = '0;
    cmd.scan_ref    = ref_cnt;
    cmd.scan_bin    = bin_cnt;
    cmd.scan_first  = (bin_cnt == '0);
    cmd.scan_last   = (bin_cnt == BIN_W'(BINS - 1));
    cmd.fetch_k     = K_IDX_W'(step);
    unique case (state)
      ST_IDLE:  cmd.clear_best  = start;
      ST_SCAN:  cmd.scan_valid  = 1'b1;
      ST_DRAIN: ;
      ST_FETCH: cmd.fetch_valid = (step < STEP_W'(K));
      ST_DIV: begin
        cmd.div_load = (step == '0);
        cmd.div_step = (step != '0);
      end
      ST_DONE:  cmd.out_load    = out_free;
      default:  ;
    endcase
  end

  // State, counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      ref_cnt   <= '0;
      bin_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        step <= '0;
      end else begin
        step <= step + 1'b1;
      end
      if (state == ST_SCAN) begin
        if (bin_cnt == BIN_W'(BINS - 1)) begin
          bin_cnt <= '0;
          ref_cnt <= ref_cnt + 1'b1;
        end else begin
          bin_cnt <= bin_cnt + 1'b1;
        end
      end else begin
        bin_cnt <= '0;
        ref_cnt <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/knnhpr_dp.sv =====
// Datapath: histogram and position memories, distance pipeline, top-K list,
// sums and a byte-per-step divide by K. Depends on knnhpr_pkg.
`timescale 1ns / 1ps

module knnhpr_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  knnhpr_pkg::in_item_t  in_item,
  input  knnhpr_pkg::dp_cmd_t   cmd,
  output knnhpr_pkg::out_item_t out_item
);
  import knnhpr_pkg::*;

  // One byte of long division by K: remainder and top byte form the partial
  // dividend, a reciprocal multiply gives the quotient byte
  function automatic logic [REM_W+SUM_D_W-1:0] div_k_step(input logic [SUM_D_W-1:0] q,
                                                          input logic [REM_W-1:0] r);
    logic [REM_W+DIGIT_W-1:0] t;
    logic [PROD_W-1:0]        prod;
    logic [DIGIT_W-1:0]       qd;
    logic [REM_W+DIGIT_W-1:0] back;
    t    = {r, q[SUM_D_W-1 -: DIGIT_W]};
    prod = PROD_W'(t) * PROD_W'(RECIP_K);
    qd   = prod[RECIP_SH +: DIGIT_W];
    back = t - (REM_W+DIGIT_W)'(qd) * (REM_W+DIGIT_W)'(K);
    return {back[REM_W-1:0], q[SUM_D_W-DIGIT_W-1:0], qd};
  endfunction

  logic [VAL_W-1:0] ref_bins [2**ADDR_W];
  logic [POS_W-1:0] ref_x    [NUM_REFS];
  logic [POS_W-1:0] ref_y    [NUM_REFS];
  logic [VAL_W-1:0] query    [BINS];

  logic wr_bin, wr_pos, wr_query;

  logic [VAL_W-1:0] rb_rd, qb_rd;
  logic             s1_valid, s1_first, s1_last;
  logic [REF_W-1:0] s1_ref;
  logic [SQ_W-1:0]  sq;
  logic [VAL_W-1:0] diff;
  logic             s2_valid, s2_first, s2_last;
  logic [REF_W-1:0] s2_ref;
  logic [DIST_W-1:0] acc;
  logic             s3_done;
  logic [REF_W-1:0] s3_ref;

  logic [DIST_W-1:0] best_d      [K];
  logic [REF_W-1:0]  best_ref    [K];
  logic [DIST_W-1:0] best_d_next [K];
  logic [REF_W-1:0]  best_ref_next [K];
  logic [K-1:0]      lt;

  logic               f_valid;
  logic [K_IDX_W-1:0] f_k;
  logic [POS_W-1:0]   x_rd, y_rd;
  logic signed [SUM_P_W-1:0] sum_x, sum_y;
  logic [SUM_D_W-1:0] sum_d;
  logic [SUM_P_W-1:0] mag_x, mag_y;

  logic [SUM_D_W-1:0] dq_x, dq_y, dq_d;
  logic [REM_W-1:0]   rm_x, rm_y, rm_d;
  logic               neg_x, neg_y;
  logic [POS_W-1:0]   q_x, q_y;

  // Decode write beats
  assign wr_bin   = in_fire && (in_item.command == CMD_REF_BIN) &&
                    (int'(in_item.entry) < NUM_REFS) && (int'(in_item.bin) < BINS);
  assign wr_pos   = in_fire && (in_item.command == CMD_REF_POS) &&
                    (int'(in_item.entry) < NUM_REFS);
  assign wr_query = in_fire && (in_item.command == CMD_QUERY_BIN) &&
                    (int'(in_item.bin) < BINS);

  // Reference histogram memory
  always_ff @(posedge clk) begin
    if (wr_bin) begin
      ref_bins[{in_item.entry[REF_W-1:0], in_item.bin[BIN_W-1:0]}] <= in_item.bin_value;
    end
    rb_rd <= ref_bins[{cmd.scan_ref, cmd.scan_bin}];
  end

  // Query histogram memory
  always_ff @(posedge clk) begin
    if (wr_query) begin
      query[in_item.bin[BIN_W-1:0]] <= in_item.bin_value;
    end
    qb_rd <= query[cmd.scan_bin];
  end

  // Position memories, read at the chosen neighbor
  always_ff @(posedge clk) begin
    if (wr_pos) begin
      ref_x[in_item.entry[REF_W-1:0]] <= in_item.pos_x;
      ref_y[in_item.entry[REF_W-1:0]] <= in_item.pos_y;
    end
    x_rd <= ref_x[best_ref[cmd.fetch_k]];
    y_rd <= ref_y[best_ref[cmd.fetch_k]];
  end

  // Distance pipeline: read, square, accumulate
  assign diff = (qb_rd >= rb_rd) ? (qb_rd - rb_rd) : (rb_rd - qb_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_done  <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_valid;
      s2_valid <= s1_valid;
      s3_done  <= s2_valid && s2_last;
    end
    s1_first <= cmd.scan_first;
    s1_last  <= cmd.scan_last;
    s1_ref   <= cmd.scan_ref;
    sq       <= diff * diff;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_ref   <= s1_ref;
    s3_ref   <= s2_ref;
    if (s2_valid) begin
      acc <= s2_first ? DIST_W'(sq) : acc + DIST_W'(sq);
    end
  end

  // Sorted insert: strictly smaller distances move ahead, ties keep lower index
  always_comb begin
    for (int i = 0; i < K; i++) begin
      lt[i] = (acc < best_d[i]);
    end
    for (int i = 0; i < K; i++) begin
      best_d_next[i]   = best_d[i];
      best_ref_next[i] = best_ref[i];
      if (lt[i]) begin
        if (i != 0 && lt[(i == 0) ? 0 : i - 1]) begin
          best_d_next[i]   = best_d[(i == 0) ? 0 : i - 1];
          best_ref_next[i] = best_ref[(i == 0) ? 0 : i - 1];
        end else begin
          best_d_next[i]   = acc;
          best_ref_next[i] = s3_ref;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_best) begin
      for (int i = 0; i < K; i++) begin
        best_d[i]   <= '1;
        best_ref[i] <= '0;
      end
    end else if (s3_done) begin
      for (int i = 0; i < K; i++) begin
        best_d[i]   <= best_d_next[i];
        best_ref[i] <= best_ref_next[i];
      end
    end
  end

  // Sum positions and distances of the chosen neighbors
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= cmd.fetch_valid;
    end
    f_k <= cmd.fetch_k;
    if (cmd.clear_best) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_d <= '0;
    end else if (f_valid) begin
      sum_x <= sum_x + SUM_P_W'(signed'(x_rd));
      sum_y <= sum_y + SUM_P_W'(signed'(y_rd));
      sum_d <= sum_d + SUM_D_W'(best_d[f_k]);
    end
  end

  // Divide magnitudes by K one byte a step, truncating toward zero
  assign mag_x = sum_x[SUM_P_W-1] ? SUM_P_W'(-sum_x) : SUM_P_W'(sum_x);
  assign mag_y = sum_y[SUM_P_W-1] ? SUM_P_W'(-sum_y) : SUM_P_W'(sum_y);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq_x  <= SUM_D_W'(mag_x);
      dq_y  <= SUM_D_W'(mag_y);
      dq_d  <= sum_d;
      rm_x  <= '0;
      rm_y  <= '0;
      rm_d  <= '0;
      neg_x <= sum_x[SUM_P_W-1];
      neg_y <= sum_y[SUM_P_W-1];
    end else if (cmd.div_step) begin
      {rm_x, dq_x} <= div_k_step(dq_x, rm_x);
      {rm_y, dq_y} <= div_k_step(dq_y, rm_y);
      {rm_d, dq_d} <= div_k_step(dq_d, rm_d);
    end
  end

  // Result register
  assign q_x = dq_x[POS_W-1:0];
  assign q_y = dq_y[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.mean_x        <= neg_x ? POS_W'(-q_x) : q_x;
      out_item.mean_y        <= neg_y ? POS_W'(-q_y) : q_y;
      out_item.mean_distance <= dq_d[MEAN_D_W-1:0];
    end
  end

endmodule

// ===== hdl/knnhpr_top_unit.sv =====
// Core of the unit: the controller and the datapath joined by the command bus.
// Depends on knnhpr_pkg, knnhpr_ctrl and knnhpr_dp.
`timescale 1ns / 1ps

module knnhpr_top_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  knnhpr_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output knnhpr_pkg::out_item_t out_item
);
  import knnhpr_pkg::*;

  dp_cmd_t cmd;
  logic    in_fire;

  // Accept an input beat
  assign in_fire = in_valid && !in_stall;

  knnhpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  knnhpr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_item  (in_item),
    .cmd      (cmd),
    .out_item (out_item)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for knn_histogram_position_regression_unit.
// Depends on knnhpr_pkg and the RTL under hdl; predicts the K-nearest means per query.
`timescale 1ns / 1ps

module tb_top;
  import knnhpr_pkg::*;

  localparam longint unsigned DIST_NONE = (64'd1 << DIST_W) - 64'd1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Shadow copy of the block's library and query histogram
  logic [VAL_W-1:0]        lib_bins [NUM_REFS][BINS];
  logic signed [POS_W-1:0] lib_x [NUM_REFS];
  logic signed [POS_W-1:0] lib_y [NUM_REFS];
  logic [VAL_W-1:0]        probe_bins [BINS];

  out_item_t means_due [$];
  int        beats_sent = 0;
  int        searches_run = 0;
  int        results_checked = 0;
  int        mismatches = 0;
  bit        steady = 1'b0;

  knn_histogram_position_regression_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Search the shadow library: keep the K smallest squared distances, lower index on ties
  function automatic out_item_t nearest_means();
    longint unsigned top_d [K];
    int              top_r [K];
    int              filled;
    int              pos;
    int              p;
    int              q;
    longint unsigned diff;
    longint unsigned d;
    longint          sx;
    longint          sy;
    longint unsigned sd;
    out_item_t       res;
    for (int i = 0; i < K; i++) begin
      top_d[i] = DIST_NONE;
      top_r[i] = 0;
    end
    filled = 0;
    for (int r = 0; r < NUM_REFS; r++) begin
      d = 0;
      for (int b = 0; b < BINS; b++) begin
        p = probe_bins[b];
        q = lib_bins[r][b];
        diff = (p >= q) ? longint'(p - q) : longint'(q - p);
        d += diff * diff;
      end
      if (filled == K && !(d < top_d[K-1])) continue;
      pos = filled;
      while (pos > 0 && d < top_d[pos-1]) pos--;
      for (int i = (filled < K) ? filled : K - 1; i > pos; i--) begin
        top_d[i] = top_d[i-1];
        top_r[i] = top_r[i-1];
      end
      top_d[pos] = d;
      top_r[pos] = r;
      if (filled < K) filled++;
    end
    sx = 0;
    sy = 0;
    sd = 0;
    for (int i = 0; i < filled; i++) begin
      sx += lib_x[top_r[i]];
      sy += lib_y[top_r[i]];
      sd += top_d[i];
    end
    // Signed division truncates toward zero
    res.mean_x        = POS_W'(sx / longint'(filled));
    res.mean_y        = POS_W'(sy / longint'(filled));
    res.mean_distance = MEAN_D_W'(sd / longint'(filled));
    return res;
  endfunction

  // Mirror one accepted beat into the shadow state
  function automatic void apply_beat(in_item_t it);
    case (it.command)
      CMD_REF_BIN: begin
        if (int'(it.entry) < NUM_REFS && int'(it.bin) < BINS)
          lib_bins[it.entry][it.bin] = it.bin_value;
      end
      CMD_REF_POS: begin
        if (int'(it.entry) < NUM_REFS) begin
          lib_x[it.entry] = it.pos_x;
          lib_y[it.entry] = it.pos_y;
        end
      end
      CMD_QUERY_BIN: begin
        if (int'(it.bin) < BINS) probe_bins[it.bin] = it.bin_value;
        if (it.last) begin
          means_due.push_back(nearest_means());
          searches_run++;
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one beat from a falling edge; return at the falling edge after it is taken
  task automatic send_beat(in_item_t it);
    while (!steady && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_beat(it);
    beats_sent++;
    @(negedge clk);
  endtask

  function automatic in_item_t scrambled();
    return in_item_t'({$urandom, $urandom});
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_pos();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic put_ref_bin(int e, int b, int v, bit l);
    in_item_t it;
    it = scrambled();
    it.command   = CMD_REF_BIN;
    it.entry     = 8'(e);
    it.bin       = 5'(b);
    it.bin_value = VAL_W'(v);
    it.last      = l;
    send_beat(it);
  endtask

  task automatic put_ref_pos(int e, int x, int y, bit l);
    in_item_t it;
    it = scrambled();
    it.command = CMD_REF_POS;
    it.entry   = 8'(e);
    it.pos_x   = POS_W'(x);
    it.pos_y   = POS_W'(y);
    it.last    = l;
    send_beat(it);
  endtask

  task automatic put_query_bin(int b, int v, bit l);
    in_item_t it;
    it = scrambled();
    it.command   = CMD_QUERY_BIN;
    it.bin       = 5'(b);
    it.bin_value = VAL_W'(v);
    it.last      = l;
    send_beat(it);
  endtask

  task automatic put_nop(bit l);
    in_item_t it;
    it = scrambled();
    it.command = CMD_NOP;
    it.last    = l;
    send_beat(it);
  endtask

  // Write every reference; the corner variant puts all bins at full scale
  task automatic fill_library(bit far_corner);
    int v;
    for (int r = 0; r < NUM_REFS; r++) begin
      for (int b = 0; b < BINS; b++) begin
        if (far_corner || r == 1) v = 65535;
        else if (r == 0) v = 0;
        else v = pick_value();
        put_ref_bin(r, b, v, 1'b0);
      end
      if (far_corner && r < K) put_ref_pos(r, -32768, 32767, 1'b0);
      else if (r == 0) put_ref_pos(r, 32767, -32768, 1'b0);
      else put_ref_pos(r, pick_pos(), pick_pos(), 1'b0);
    end
  endtask

  task automatic query_flat(int v);
    for (int b = 0; b < BINS; b++) put_query_bin(b, v, b == BINS - 1);
  endtask

  // Query near one reference; spread sets the per-bin noise
  task automatic query_near(int src, int spread);
    int v;
    for (int b = 0; b < BINS; b++) begin
      v = int'(lib_bins[src][b]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      put_query_bin(b, v, b == BINS - 1);
    end
  endtask

  task automatic test_library_fill();
    fill_library(1'b0);
    for (int b = 0; b < BINS; b++) put_query_bin(b, pick_value(), b == BINS - 1);
  endtask

  task automatic test_exact_match();
    query_near(7, 0);
  endtask

  task automatic test_bin_extremes();
    query_flat(0);
    query_flat(65535);
  endtask

  // Last is ignored on loads and no-ops; a mid-range query bin may still end the query
  task automatic test_ignored_beats();
    put_nop(1'b1);
    put_nop(1'b0);
    put_ref_bin(200, 17, 12345, 1'b1);
    put_ref_pos(200, -5, 5, 1'b1);
    put_query_bin(3, 40000, 1'b0);
    put_query_bin(12, 0, 1'b1);
  endtask

  // Four references at distance zero: the three lowest indexes win, negative mean truncates
  task automatic test_tie_order();
    int tie_refs [4];
    tie_refs = '{40, 90, 150, 200};
    foreach (tie_refs[i])
      for (int b = 0; b < BINS; b++) put_ref_bin(tie_refs[i], b, b * 2000 + 123, 1'b0);
    put_ref_pos(40, -1, 1, 1'b0);
    put_ref_pos(90, -1, 1, 1'b0);
    put_ref_pos(150, -2, 0, 1'b0);
    put_ref_pos(200, 30000, 30000, 1'b0);
    for (int b = 0; b < BINS; b++) put_query_bin(b, b * 2000 + 123, b == BINS - 1);
  endtask

  // Every reference at full scale against an empty query: largest mean distance
  task automatic test_far_corner();
    fill_library(1'b1);
    query_flat(0);
    fill_library(1'b0);
  endtask

  task automatic test_random_traffic();
    int updates;
    int src;
    int dst;
    int spreads [3];
    int n;
    spreads = '{0, 3, 300};
    for (int round = 0; round < 52; round++) begin
      // Rounds 20 to 29 run without any idling on either side
      steady = (round >= 20 && round < 30);
      updates = $urandom_range(0, 12);
      for (int u = 0; u < updates; u++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: put_ref_bin($urandom_range(0, NUM_REFS - 1),
                                     $urandom_range(0, BINS - 1), pick_value(),
                                     1'($urandom_range(0, 1)));
          5, 6:          put_ref_pos($urandom_range(0, NUM_REFS - 1), pick_pos(), pick_pos(),
                                     1'($urandom_range(0, 1)));
          7:             put_nop(1'($urandom_range(0, 1)));
          default:       put_query_bin($urandom_range(0, BINS - 1), pick_value(), 1'b0);
        endcase
      end
      // Plant a duplicate reference to provoke ties
      if ($urandom_range(0, 5) == 0) begin
        src = $urandom_range(0, NUM_REFS - 1);
        dst = $urandom_range(0, NUM_REFS - 1);
        for (int b = 0; b < BINS; b++) put_ref_bin(dst, b, lib_bins[src][b], 1'b0);
      end
      case ($urandom_range(0, 3))
        0, 1: query_near($urandom_range(0, NUM_REFS - 1), spreads[$urandom_range(0, 2)]);
        2: begin
          for (int b = 0; b < BINS; b++) put_query_bin(b, pick_value(), b == BINS - 1);
        end
        default: begin
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++)
            put_query_bin($urandom_range(0, BINS - 1), pick_value(), i == n - 1);
        end
      endcase
    end
    steady = 1'b0;
  endtask

  // Receiver side: stall at random about 9 percent of the time, except in the steady stretch
  always @(negedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < 9);
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : check_means
    out_item_t due;
    if (!rst && out_valid && !out_stall) begin
      if (means_due.size() == 0) begin
        $display("%0t unexpected result: mean_x %0d mean_y %0d mean_distance %0d", $time,
                 out_item.mean_x, out_item.mean_y, out_item.mean_distance);
        mismatches++;
      end else begin
        due = means_due.pop_front();
        results_checked++;
        if (out_item.mean_x !== due.mean_x) begin
          $display("%0t mean_x: expected %0d, got %0d", $time, due.mean_x, out_item.mean_x);
          mismatches++;
        end
        if (out_item.mean_y !== due.mean_y) begin
          $display("%0t mean_y: expected %0d, got %0d", $time, due.mean_y, out_item.mean_y);
          mismatches++;
        end
        if (out_item.mean_distance !== due.mean_distance) begin
          $display("%0t mean_distance: expected %0d, got %0d", $time,
                   due.mean_distance, out_item.mean_distance);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_library_fill();
    test_exact_match();
    test_bin_extremes();
    test_ignored_beats();
    test_tie_order();
    test_far_corner();
    test_random_traffic();

    // Drain: wait for outstanding results, then wait longer than a search for strays
    in_valid <= 1'b0;
    while (means_due.size() != 0) @(posedge clk);
    repeat (9000) @(posedge clk);

    $display("covered %0d beats, %0d nearest-neighbor searches, %0d results checked",
             beats_sent, searches_run, results_checked);
    $display("mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[knn_histogram_position_regression_unit] OK");
    end else begin
      $display("[knn_histogram_position_regression_unit] ERROR");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", means_due.size());
    $display("[knn_histogram_position_regression_unit] ERROR");
    $finish;
  end

endmodule
